FILE: sv/umr_pkg.sv
`default_nettype none
package umr_pkg;

  localparam int unsigned MaxResults = 6;
  localparam int unsigned IdxW = 3;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] LeadTwoLo = 8'hC2;
  localparam logic [7:0] LeadFour  = 8'hF4;
  localparam logic [7:0] AsciiHi   = 8'h7F;
  localparam logic [7:0] LeadE0    = 8'hE0;
  localparam logic [7:0] LeadED    = 8'hED;
  localparam logic [7:0] LeadF0    = 8'hF0;
  localparam logic [7:0] SecA0     = 8'hA0;
  localparam logic [7:0] Sec90     = 8'h90;
  localparam logic [7:0] Sec8F     = 8'h8F;

  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  // Everything the back end needs to emit the results of one input byte.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [MaxResults-1:0]      repl;
    logic [IdxW-1:0]            count;
    logic                       last;
  } desc_t;

endpackage
`default_nettype wire

FILE: sv/umr_front.sv
`default_nettype none
module umr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          last_in_i,
  input  wire logic          full_i,
  output logic               push_o,
  output umr_pkg::desc_t     desc_o
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] h0_q, h0_d, h1_q, h1_d, h2_q, h2_d;
  logic [1:0] need;
  logic       ok;
  logic       do_lead;
  logic [umr_pkg::IdxW-1:0] n;
  logic       accept;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    need = (h0_q < umr_pkg::LeadE0) ? 2'd1 : (h0_q < umr_pkg::LeadF0) ? 2'd2 : 2'd3;
    ok = (in_byte_i & umr_pkg::ContMask) == umr_pkg::ContCode;
    if (cnt_q == 2'd1) begin
      if (h0_q == umr_pkg::LeadE0 && in_byte_i < umr_pkg::SecA0) ok = 1'b0;
      if (h0_q == umr_pkg::LeadF0 && in_byte_i < umr_pkg::Sec90) ok = 1'b0;
      if (h0_q == umr_pkg::LeadFour && in_byte_i > umr_pkg::Sec8F) ok = 1'b0;
    end
  end

  always_comb begin
    desc_o  = '0;
    n       = '0;
    do_lead = 1'b0;
    cnt_d   = cnt_q;
    h0_d    = h0_q;
    h1_d    = h1_q;
    h2_d    = h2_q;

    if (cnt_q == 2'd0) begin
      do_lead = 1'b1;
    end else if (!ok) begin
      desc_o.bytes[n] = umr_pkg::ReplByte0; desc_o.repl[n] = 1'b1; n = n + 3'd1;
      desc_o.bytes[n] = umr_pkg::ReplByte1; desc_o.repl[n] = 1'b1; n = n + 3'd1;
      desc_o.bytes[n] = umr_pkg::ReplByte2; desc_o.repl[n] = 1'b1; n = n + 3'd1;
      cnt_d   = 2'd0;
      do_lead = 1'b1;
    end else if (cnt_q >= need) begin
      if (h0_q == umr_pkg::LeadED && h1_q >= umr_pkg::SecA0) begin
        // A surrogate encoding is dropped as a whole.
        desc_o.bytes[0] = umr_pkg::ReplByte0;
        desc_o.bytes[1] = umr_pkg::ReplByte1;
        desc_o.bytes[2] = umr_pkg::ReplByte2;
        desc_o.repl[2:0] = 3'b111;
        n = 3'd3;
      end else begin
        desc_o.bytes[0] = h0_q;
        desc_o.bytes[1] = (cnt_q >= 2'd2) ? h1_q : in_byte_i;
        desc_o.bytes[2] = (cnt_q == 2'd3) ? h2_q : in_byte_i;
        desc_o.bytes[3] = in_byte_i;
        n = {1'b0, cnt_q} + 3'd1;
      end
      cnt_d = 2'd0;
    end else begin
      if (cnt_q == 2'd1) h1_d = in_byte_i;
      else h2_d = in_byte_i;
      cnt_d = cnt_q + 2'd1;
    end

    if (do_lead) begin
      if (in_byte_i <= umr_pkg::AsciiHi) begin
        desc_o.bytes[n] = in_byte_i; n = n + 3'd1;
      end else if (in_byte_i inside {[umr_pkg::LeadTwoLo:umr_pkg::LeadFour]}) begin
        h0_d  = in_byte_i;
        cnt_d = 2'd1;
      end else begin
        desc_o.bytes[n] = umr_pkg::ReplByte0; desc_o.repl[n] = 1'b1; n = n + 3'd1;
        desc_o.bytes[n] = umr_pkg::ReplByte1; desc_o.repl[n] = 1'b1; n = n + 3'd1;
        desc_o.bytes[n] = umr_pkg::ReplByte2; desc_o.repl[n] = 1'b1; n = n + 3'd1;
      end
    end

    if (last_in_i) begin
      // End of string flushes a partial sequence as one replacement.
      if (cnt_d != 2'd0) begin
        desc_o.bytes[n] = umr_pkg::ReplByte0; desc_o.repl[n] = 1'b1; n = n + 3'd1;
        desc_o.bytes[n] = umr_pkg::ReplByte1; desc_o.repl[n] = 1'b1; n = n + 3'd1;
        desc_o.bytes[n] = umr_pkg::ReplByte2; desc_o.repl[n] = 1'b1; n = n + 3'd1;
      end
      cnt_d = 2'd0;
    end

    desc_o.count = n;
    desc_o.last  = last_in_i;
  end

  assign push_o = accept & (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h0_q <= h0_d;
      h1_q <= h1_d;
      h2_q <= h2_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/umr_queue.sv
`default_nettype none
module umr_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (do_pop)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

FILE: sv/umr_back.sv
`default_nettype none
module umr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire umr_pkg::desc_t desc_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                is_replacement_o,
  output logic                run_last_o,
  output logic                string_last_o
);

  logic [umr_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     xfer;

  assign out_valid_o      = ~empty_i;
  assign out_byte_o       = desc_i.bytes[idx_q];
  assign is_replacement_o = desc_i.repl[idx_q];
  assign run_last_o       = (idx_q == desc_i.count - 3'd1);
  assign string_last_o    = run_last_o & desc_i.last;
  assign xfer             = out_valid_o & out_ready_i;
  // The descriptor leaves the queue with the transfer of its final byte.
  assign pop_o            = xfer & run_last_o;

  always_comb begin
    idx_d = idx_q;
    if (xfer) idx_d = run_last_o ? '0 : idx_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/utf8_malformed_replacer_top.sv
`default_nettype none
// UTF-8 sanitizer. Raw string bytes enter on the in channel (in_byte_i, with
// last_in_i on the final byte) and sanitized bytes leave on the out channel.
// Well-formed sequences pass unchanged; each maximal malformed subpart, or
// whole surrogate encoding, is replaced by EF BF BD with is_replacement_o
// set. run_last_o marks the last output byte caused by one input byte,
// string_last_o the final byte of the string.
// The front end classifies one byte per cycle while the queue has room and
// writes a descriptor of all results of that byte into a queue of QueueDepth
// entries; the back end sends one output byte per cycle from the queue head
// while out_ready_i is high, and this limits throughput: a byte that yields k
// results is sent as k output bytes. A byte's first result is offered once its
// registered descriptor reaches the queue head.
// Bytes that yield no result (held leads) take no queue slot.
// When the receiver stalls, the queue fills and in_ready_o drops when full.
// Reset clears the held sequence count, the queue and the output index.
module utf8_malformed_replacer_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       last_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            is_replacement_o,
  output logic            run_last_o,
  output logic            string_last_o
);

  umr_pkg::desc_t push_desc, head_desc;
  logic           push, pop, full, empty;

  umr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .last_in_i  (last_in_i),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  umr_queue #(
    .Width ($bits(umr_pkg::desc_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .pop_i   (pop),
    .rdata_o (head_desc),
    .full_o  (full),
    .empty_o (empty)
  );

  umr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .desc_i           (head_desc),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .is_replacement_o (is_replacement_o),
    .run_last_o       (run_last_o),
    .string_last_o    (string_last_o)
  );

endmodule
`default_nettype wire
